// ----- hdl/mste_pkg.sv -----
// mste_pkg: shared types and constants for the multi-slot timeout engine
// holds payload structs, status and operation codes, controller command/status structs
// no dependencies
`default_nettype none

package mste_pkg;

  // default number of timeout slots
  localparam int unsigned SLOTS_DEFAULT = 32;

  // configuration port
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam logic [PADDR_W-1:0] ADDR_CHECK_INTERVAL = 3'd0;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd5;

  // operation codes
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_STOP    = 2'd1,
    OP_RESTART = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_DONE      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_SKIPPED   = 3'd6,
    ST_NO_EXPIRY = 3'd7
  } status_e;

  // input item
  typedef struct packed {
    op_e         operation;
    logic [31:0] now_ms;
    logic [31:0] limit_ms;
    logic [31:0] match_id;
  } in_item_t;

  // result item
  typedef struct packed {
    status_e     status;
    logic [31:0] result_id;
    logic        last;
  } out_item_t;

  // one slot entry in the slot memory
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] timeout;
    logic [31:0] start;
  } slot_entry_t;

  // source of the result id
  typedef enum logic [1:0] {
    SEL_ZERO    = 2'd0,
    SEL_NEXT_ID = 2'd1,
    SEL_PEND    = 2'd2
  } id_sel_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_START_SCAN,
    S_FIND_SCAN,
    S_TICK_SCAN,
    S_TICK_END,
    S_RESPOND
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    ready;
    logic    idx_clr;
    logic    idx_inc;
    logic    start_write;
    logic    restart_write;
    logic    release_slot;
    logic    scan_upd;
    logic    pend_set;
    logic    pend_clr;
    logic    out_load;
    status_e out_status;
    id_sel_e out_sel;
    logic    out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic tmo_zero;
    logic too_soon;
    logic at_end;
    logic cur_free;
    logic id_match;
    logic expired;
    logic pend_valid;
    logic can_emit;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/mste_ram.sv -----
// mste_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mste_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/mste_datapath.sv -----
// mste_datapath: item register, slot valid bits, slot memory, id counter, scan time,
// pending expiry and output register; apb configuration register
// depends on mste_pkg and mste_ram
`default_nettype none

module mste_datapath #(
  parameter int unsigned SLOTS = mste_pkg::SLOTS_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire mste_pkg::in_item_t                in_data_i,
  input  wire mste_pkg::cmd_t                    cmd_i,
  output mste_pkg::sts_t                         sts_o,
  input  wire logic                              out_stall_i,
  output logic                                   out_valid_o,
  output mste_pkg::out_item_t                    out_data_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mste_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [mste_pkg::PDATA_W-1:0]      pwdata,
  output logic      [mste_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready
);

  import mste_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned VW    = 1 << IDX_W;

  in_item_t            item_q;
  logic [INTERVAL_W-1:0] interval_q;
  logic [CNT_W-1:0]    idx_q, idx_d, idx_nxt;
  logic [IDX_W-1:0]    cur_idx, rd_addr;
  logic [VW-1:0]       valid_q, valid_d;
  logic [31:0]         next_id_q, next_id_d, next_id_inc;
  logic [31:0]         last_scan_q;
  logic [31:0]         pend_id_q;
  logic                pend_valid_q;
  logic                out_valid_q;
  out_item_t           out_q;
  logic [31:0]         out_id;
  logic [31:0]         interval_ext, eff_tmo, elapsed, since_scan;
  logic                valid_cur, at_end, can_emit, accept, cfg_wr;
  logic                ram_we;
  slot_entry_t         ram_wdata, ram_rdata;
  logic [$bits(slot_entry_t)-1:0] ram_rdata_raw;

  // apb configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CHECK_INTERVAL);
  assign prdata = (paddr == ADDR_CHECK_INTERVAL) ?
                  {{(PDATA_W-INTERVAL_W){1'b0}}, interval_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
    end else if (cfg_wr) begin
      interval_q <= pwdata[INTERVAL_W-1:0];
    end
  end

  // input item register
  assign accept = in_valid_i && cmd_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  // slot index counter and memory read address
  assign idx_nxt = idx_q + CNT_W'(1);
  assign cur_idx = idx_q[IDX_W-1:0];
  assign at_end  = (idx_q == CNT_W'(SLOTS));

  always_comb begin
    idx_d   = idx_q;
    rd_addr = cur_idx;
    if (cmd_i.idx_clr) begin
      idx_d   = '0;
      rd_addr = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d   = idx_nxt;
      rd_addr = idx_nxt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // slot valid bits
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.start_write) begin
      valid_d[cur_idx] = 1'b1;
    end
    if (cmd_i.release_slot) begin
      valid_d[cur_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign valid_cur = !at_end && valid_q[cur_idx];

  // slot memory write data
  assign interval_ext = {{(32-INTERVAL_W){1'b0}}, interval_q};
  assign eff_tmo      = (item_q.limit_ms < interval_ext) ? interval_ext : item_q.limit_ms;

  always_comb begin
    ram_wdata = ram_rdata;
    if (cmd_i.start_write) begin
      ram_wdata.id      = next_id_q;
      ram_wdata.timeout = eff_tmo;
    end
    ram_wdata.start = item_q.now_ms;
  end

  assign ram_we = cmd_i.start_write || cmd_i.restart_write;

  mste_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (VW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_idx),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = slot_entry_t'(ram_rdata_raw);

  // id counter, wraps past zero to one
  assign next_id_inc = next_id_q + 32'd1;

  always_comb begin
    next_id_d = next_id_q;
    if (cmd_i.start_write) begin
      next_id_d = (next_id_inc == 32'd0) ? 32'd1 : next_id_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q   <= 32'd1;
      last_scan_q <= '0;
    end else begin
      next_id_q <= next_id_d;
      if (cmd_i.scan_upd) begin
        last_scan_q <= item_q.now_ms;
      end
    end
  end

  // pending expired id, held until the next one shows whether it is the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.pend_set) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.pend_clr) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_set) begin
      pend_id_q <= ram_rdata.id;
    end
  end

  // output register
  assign can_emit = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.out_sel)
      SEL_NEXT_ID: out_id = next_id_q;
      SEL_PEND:    out_id = pend_id_q;
      default:     out_id = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status    <= cmd_i.out_status;
      out_q.result_id <= out_id;
      out_q.last      <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status toward the controller
  assign elapsed    = item_q.now_ms - ram_rdata.start;
  assign since_scan = item_q.now_ms - last_scan_q;

  always_comb begin
    sts_o.op         = item_q.operation;
    sts_o.tmo_zero   = (item_q.limit_ms == 32'd0);
    sts_o.too_soon   = (since_scan < interval_ext);
    sts_o.at_end     = at_end;
    sts_o.cur_free   = !at_end && !valid_q[cur_idx];
    sts_o.id_match   = valid_cur && (item_q.match_id != 32'd0) &&
                       (ram_rdata.id == item_q.match_id);
    sts_o.expired    = valid_cur && (elapsed >= ram_rdata.timeout);
    sts_o.pend_valid = pend_valid_q;
    sts_o.can_emit   = can_emit;
  end

endmodule

`default_nettype wire

// ----- hdl/mste_ctrl.sv -----
// mste_ctrl: sequencer for start, stop, restart and tick scan
// depends on mste_pkg
`default_nettype none

module mste_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire mste_pkg::sts_t sts_i,
  output mste_pkg::cmd_t      cmd_o
);

  import mste_pkg::*;

  state_e  state_q, state_d;
  status_e resp_q, resp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= ST_DONE;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_START: begin
            if (sts_i.tmo_zero) begin
              resp_d  = ST_REJECTED;
              state_d = S_RESPOND;
            end else begin
              state_d = S_START_SCAN;
            end
          end
          OP_STOP, OP_RESTART: state_d = S_FIND_SCAN;
          default: begin
            if (sts_i.too_soon) begin
              resp_d  = ST_SKIPPED;
              state_d = S_RESPOND;
            end else begin
              state_d = S_TICK_SCAN;
            end
          end
        endcase
      end
      S_START_SCAN: begin
        if (sts_i.at_end) begin
          resp_d  = ST_NO_SLOT;
          state_d = S_RESPOND;
        end else if (sts_i.cur_free && sts_i.can_emit) begin
          state_d = S_IDLE;
        end
      end
      S_FIND_SCAN: begin
        if (sts_i.at_end) begin
          resp_d  = ST_NOT_FOUND;
          state_d = S_RESPOND;
        end else if (sts_i.id_match) begin
          resp_d  = ST_DONE;
          state_d = S_RESPOND;
        end
      end
      S_TICK_SCAN: begin
        if (sts_i.at_end) begin
          state_d = S_TICK_END;
        end
      end
      S_TICK_END, S_RESPOND: begin
        if (sts_i.can_emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = ST_DONE;
    cmd_o.out_sel    = SEL_ZERO;
    case (state_q)
      S_IDLE: begin
        cmd_o.ready   = 1'b1;
        cmd_o.idx_clr = 1'b1;
      end
      S_DECODE: begin
        cmd_o.idx_clr  = 1'b1;
        cmd_o.scan_upd = (sts_i.op == OP_TICK) && !sts_i.too_soon;
      end
      S_START_SCAN: begin
        if (!sts_i.at_end) begin
          if (!sts_i.cur_free) begin
            cmd_o.idx_inc = 1'b1;
          end else if (sts_i.can_emit) begin
            cmd_o.start_write = 1'b1;
            cmd_o.out_load    = 1'b1;
            cmd_o.out_status  = ST_STARTED;
            cmd_o.out_sel     = SEL_NEXT_ID;
            cmd_o.out_last    = 1'b1;
          end
        end
      end
      S_FIND_SCAN: begin
        if (!sts_i.at_end) begin
          if (sts_i.id_match) begin
            cmd_o.release_slot  = (sts_i.op == OP_STOP);
            cmd_o.restart_write = (sts_i.op == OP_RESTART);
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      S_TICK_SCAN: begin
        if (!sts_i.at_end) begin
          if (!sts_i.expired) begin
            cmd_o.idx_inc = 1'b1;
          end else if (!sts_i.pend_valid) begin
            cmd_o.pend_set     = 1'b1;
            cmd_o.release_slot = 1'b1;
            cmd_o.idx_inc      = 1'b1;
          end else if (sts_i.can_emit) begin
            // push out the previous expiry, it is not the last one
            cmd_o.out_load     = 1'b1;
            cmd_o.out_status   = ST_EXPIRED;
            cmd_o.out_sel      = SEL_PEND;
            cmd_o.pend_set     = 1'b1;
            cmd_o.release_slot = 1'b1;
            cmd_o.idx_inc      = 1'b1;
          end
        end
      end
      S_TICK_END: begin
        if (sts_i.can_emit) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.pend_clr = 1'b1;
          if (sts_i.pend_valid) begin
            cmd_o.out_status = ST_EXPIRED;
            cmd_o.out_sel    = SEL_PEND;
          end else begin
            cmd_o.out_status = ST_NO_EXPIRY;
          end
        end
      end
      S_RESPOND: begin
        if (sts_i.can_emit) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = resp_q;
          cmd_o.out_last   = 1'b1;
        end
      end
      default: begin
        cmd_o.idx_clr = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/multi_slot_timeout_engine.sv -----
// multi_slot_timeout_engine: top level of the one-shot timeout slot table
// depends on mste_pkg, mste_ctrl, mste_datapath and mste_ram
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one operation
//   with the current millisecond time: start, stop, restart or tick scan.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns results;
//   every item gives one result, a scanning tick one per expired slot or one
//   no-expiry result, and the final result of an item has last set.
//   The apb port holds check_interval_ms at address 0.
//   One item is in work at a time. Start, stop and restart walk the slots one
//   per cycle through the single read port of the slot memory, and a tick that
//   scans walks every slot.
//   A finished result waits in the output register while the next item is
//   taken; while the receiver stalls and another result is due, the walk
//   pauses at the current slot.
//   Reset clears all slot valid bits at once, sets the next id to one, the
//   last scan time to zero and the interval to 5; no clearing pass is needed.
`default_nettype none

module multi_slot_timeout_engine #(
  parameter int unsigned SLOTS = mste_pkg::SLOTS_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire mste_pkg::in_item_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output mste_pkg::out_item_t               out_data_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mste_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mste_pkg::PDATA_W-1:0] pwdata,
  output logic      [mste_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);

  import mste_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  mste_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot table and result path
  mste_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  assign in_stall_o = !cmd.ready;

endmodule

`default_nettype wire

// ----- hdl/mste_checker.sv -----
// mste_checker: port-level assertions for multi_slot_timeout_engine, with bind
// depends on mste_pkg
`default_nettype none

module mste_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire mste_pkg::out_item_t out_data_o
);

  import mste_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // only started and expired results carry an id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_STARTED && out_data_o.status != ST_EXPIRED
    |-> out_data_o.result_id == 32'd0)
    else $error("nonzero id on a result without id");

  // only expiry results may be followed by more results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_EXPIRED |-> out_data_o.last)
    else $error("single result without last");

  // assigned and expired ids are never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_STARTED || out_data_o.status == ST_EXPIRED)
    |-> out_data_o.result_id != 32'd0)
    else $error("zero timer id reported");

endmodule

bind multi_slot_timeout_engine mste_checker u_mste_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- verif/mste_tb_pkg.sv -----
// timeout table scoreboard: predicts the results of the slot table and checks them
// depends on mste_pkg for the payload structs, operation and status codes
package mste_tb_pkg;
  import mste_pkg::*;

  class timeout_table_model;
    logic [15:0] interval;
    bit          slot_live  [SLOTS_DEFAULT];
    logic [31:0] slot_ident [SLOTS_DEFAULT];
    logic [31:0] slot_limit [SLOTS_DEFAULT];
    logic [31:0] slot_begin [SLOTS_DEFAULT];
    logic [31:0] next_ident;
    logic [31:0] last_scan;
    out_item_t   due_results[$];
    int unsigned errors;

    // state right after reset
    function new();
      interval   = INTERVAL_RESET;
      next_ident = 32'd1;
      last_scan  = '0;
      errors     = 0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
    endfunction

    function void queue_result(status_e st, logic [31:0] ident, logic fin);
      out_item_t r;
      r.status    = st;
      r.result_id = ident;
      r.last      = fin;
      due_results.push_back(r);
    endfunction

    // work out the results of one accepted command transfer
    function void take_command(in_item_t cmd);
      logic [31:0] span;
      int          hit;
      int          fired;
      hit   = -1;
      fired = 0;
      case (cmd.operation)
        OP_START: begin
          if (cmd.limit_ms == '0) begin
            queue_result(ST_REJECTED, '0, 1'b1);
          end else begin
            // short timeouts are raised to the check interval
            span = (cmd.limit_ms < {16'd0, interval}) ? {16'd0, interval} : cmd.limit_ms;
            for (int i = SLOTS_DEFAULT - 1; i >= 0; i--) begin
              if (!slot_live[i]) hit = i;
            end
            if (hit < 0) begin
              queue_result(ST_NO_SLOT, '0, 1'b1);
            end else begin
              slot_live[hit]  = 1'b1;
              slot_ident[hit] = next_ident;
              slot_limit[hit] = span;
              slot_begin[hit] = cmd.now_ms;
              queue_result(ST_STARTED, next_ident, 1'b1);
              // ids wrap past all ones back to one, never zero
              next_ident = next_ident + 32'd1;
              if (next_ident == '0) next_ident = 32'd1;
            end
          end
        end
        OP_STOP, OP_RESTART: begin
          if (cmd.match_id != '0) begin
            foreach (slot_live[i]) begin
              if (hit < 0 && slot_live[i] && slot_ident[i] == cmd.match_id) hit = i;
            end
          end
          if (hit < 0) begin
            queue_result(ST_NOT_FOUND, '0, 1'b1);
          end else begin
            if (cmd.operation == OP_STOP) slot_live[hit] = 1'b0;
            else slot_begin[hit] = cmd.now_ms;
            queue_result(ST_DONE, '0, 1'b1);
          end
        end
        default: begin
          // tick: skip when the last scan is too recent, else expire in slot order
          span = cmd.now_ms - last_scan;
          if (span < {16'd0, interval}) begin
            queue_result(ST_SKIPPED, '0, 1'b1);
          end else begin
            last_scan = cmd.now_ms;
            foreach (slot_live[i]) begin
              if (slot_live[i]) begin
                span = cmd.now_ms - slot_begin[i];
                if (span >= slot_limit[i]) begin
                  queue_result(ST_EXPIRED, slot_ident[i], 1'b0);
                  slot_live[i] = 1'b0;
                  fired++;
                end
              end
            end
            if (fired == 0) queue_result(ST_NO_EXPIRY, '0, 1'b1);
            else due_results[due_results.size() - 1].last = 1'b1;
          end
        end
      endcase
    endfunction

    // compare one result transfer with the oldest outstanding result
    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d id %h last %b",
               got.status, got.result_id, got.last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.result_id !== want.result_id) begin
        $error("result_id: expected %h, actual %h", want.result_id, got.result_id);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned free_slots();
      int unsigned n;
      n = 0;
      foreach (slot_live[i]) if (!slot_live[i]) n++;
      return n;
    endfunction

    function logic [31:0] pick_live_id();
      logic [31:0] pool[$];
      foreach (slot_live[i]) if (slot_live[i]) pool.push_back(slot_ident[i]);
      if (pool.size() == 0) return '0;
      return pool[$urandom_range(0, pool.size() - 1)];
    endfunction
  endclass

endpackage

// ----- verif/tb_multi_slot_timeout_engine.sv -----
// testbench for multi_slot_timeout_engine: directed and random command streams,
// random input gaps and result stalls, results checked against a scoreboard prediction
// depends on mste_pkg, mste_tb_pkg and the engine rtl
module tb_multi_slot_timeout_engine;
  import mste_pkg::*;
  import mste_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = SLOTS_DEFAULT + 8;
  localparam int unsigned HOLD_CYCLES   = 400;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  timeout_table_model model;
  logic [31:0]        clock_ms;
  int unsigned        sent;
  bit                 hold_armed;

  multi_slot_timeout_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_multi_slot_timeout_engine: done, errors");
    $finish;
  end

  // note accepted commands and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && !in_stall_o) model.take_command(in_data_i);
      if (out_valid_o && !out_stall_i) model.check_result(out_data_o);
    end
  end

  // result side stalls: short bursts, open stretches, a few long holds
  initial begin : receiver
    int unsigned pick;
    int unsigned len;
    logic        hold;
    bit          hold_taken;
    hold_taken = 1'b0;
    forever begin
      pick = $urandom_range(0, 99);
      if (hold_armed && !hold_taken) begin
        // one long hold-off while commands keep coming
        hold_taken = 1'b1;
        hold = 1'b1;
        len  = HOLD_CYCLES;
      end else if (pick < 50) begin
        hold = 1'b0;
        len  = $urandom_range(1, 4);
      end else if (pick < 85) begin
        hold = 1'b1;
        len  = $urandom_range(1, 3);
      end else if (pick < 95) begin
        hold = 1'b0;
        len  = $urandom_range(20, 80);
      end else begin
        hold = 1'b1;
        len  = $urandom_range(10, 60);
      end
      out_stall_i <= hold;
      repeat (len) @(posedge clk_i);
    end
  end

  // offer one command until transferred, then maybe leave a gap
  task automatic send_item(op_e op, logic [31:0] at_ms, logic [31:0] span_ms,
                           logic [31:0] ident);
    in_item_t    it;
    int unsigned r;
    int unsigned gap;
    it.operation = op;
    it.now_ms    = at_ms;
    it.limit_ms  = span_ms;
    it.match_id  = ident;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // apb write of the check interval, setup then access
  task automatic write_interval(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CHECK_INTERVAL;
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model.interval = value;
  endtask

  // wait until every predicted result has arrived and the engine is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (model.due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly well-formed timer traffic on a running clock, some noise
  task automatic random_phase(int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned r;
    int unsigned n;
    logic [31:0] iv;
    logic [31:0] span;
    logic [31:0] ident;
    goal     = sent + count;
    clock_ms = $urandom;
    while (sent < goal) begin
      iv   = {16'd0, model.interval};
      pick = $urandom_range(0, 99);
      if (pick < 34) begin
        // a few starts, timeouts mostly near the interval
        n = $urandom_range(1, 4);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 80) span = $urandom_range(1, 4 * iv + 4);
          else if (r < 90) span = '0;
          else span = $urandom;
          clock_ms = clock_ms + $urandom_range(0, 2);
          send_item(OP_START, clock_ms, span, $urandom);
        end
      end else if (pick < 54) begin
        // stop or restart a live timer, sometimes a random id
        ident = (pick < 50) ? model.pick_live_id() : $urandom;
        clock_ms = clock_ms + $urandom_range(0, iv);
        send_item($urandom_range(0, 1) ? OP_STOP : OP_RESTART, clock_ms, $urandom, ident);
      end else if (pick < 75) begin
        // ticks spaced around the check interval
        n = $urandom_range(1, 4);
        repeat (n) begin
          clock_ms = clock_ms + $urandom_range(0, 2 * iv + 1);
          send_item(OP_TICK, clock_ms, $urandom, $urandom);
        end
      end else if (pick < 77) begin
        // fill the table past full, then let the new timers expire in one scan
        n = model.free_slots() + 2;
        repeat (n) begin
          clock_ms = clock_ms + $urandom_range(0, 1);
          send_item(OP_START, clock_ms, $urandom_range(1, 2 * iv), $urandom);
        end
        repeat (2) begin
          clock_ms = clock_ms + 5 * iv + $urandom_range(0, 100);
          send_item(OP_TICK, clock_ms, $urandom, $urandom);
        end
      end else begin
        // noise: any operation, any field values
        send_item(op_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    model       = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    sent        = 0;
    hold_armed  = 1'b0;
    clock_ms    = 32'd1000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rejects, raised timeout, unknown ids, skip, expiry, wrap
    send_item(OP_START,   32'd1000,     32'd0,          32'hFFFF_FFFF);
    send_item(OP_START,   32'd1000,     32'd2,          32'd0);
    send_item(OP_START,   32'd1000,     32'd50,         32'd0);
    send_item(OP_START,   32'd1000,     32'hFFFF_FFFF,  32'd0);
    send_item(OP_STOP,    32'd1001,     32'd0,          32'd0);
    send_item(OP_STOP,    32'd1001,     32'd0,          32'hFFFF_FFFF);
    send_item(OP_RESTART, 32'd1001,     32'hFFFF_FFFF,  32'hDEAD_BEEF);
    send_item(OP_RESTART, 32'd1002,     32'd0,          32'd2);
    send_item(OP_TICK,    32'd1003,     32'd0,          32'd0);
    send_item(OP_TICK,    32'd1006,     32'd0,          32'd0);
    send_item(OP_TICK,    32'd1060,     32'd0,          32'd0);
    send_item(OP_STOP,    32'd1061,     32'd0,          32'd3);
    send_item(OP_STOP,    32'd1061,     32'd0,          32'd3);
    send_item(OP_START,   32'hFFFF_FFF0, 32'h20,        32'd0);
    send_item(OP_START,   32'hFFFF_FFF0, 32'd1,         32'd0);
    send_item(OP_TICK,    32'h0000_0010, 32'd0,         32'd0);
    send_item(OP_START,   32'd0,        32'h8000_0000,  32'd0);
    send_item(OP_TICK,    32'hFFFF_FFFF, 32'd0,         32'd0);
    send_item(OP_RESTART, 32'hFFFF_FFFF, 32'd0,         32'd6);
    send_item(OP_START,   32'd0,        32'd5,          32'd0);
    send_item(OP_TICK,    32'd4,        32'd0,          32'd0);
    send_item(OP_RESTART, 32'd4,        32'd0,          32'd7);
    send_item(OP_STOP,    32'd4,        32'd0,          32'd7);
    settle();

    // random phases across interval settings, extremes included
    write_interval(16'd1);
    hold_armed = 1'b1;
    random_phase(115);
    settle();
    write_interval(16'hFFFF);
    random_phase(115);
    settle();
    write_interval(16'($urandom_range(2, 2000)));
    random_phase(115);
    settle();
    write_interval(INTERVAL_RESET);
    random_phase(115);
    settle();

    if (model.errors == 0 && model.due_results.size() == 0) begin
      $display("tb_multi_slot_timeout_engine: done, clean");
    end else begin
      $display("tb_multi_slot_timeout_engine: done, errors");
    end
    $finish;
  end

endmodule

// ----- multi_slot_timeout_engine.f -----
hdl/mste_pkg.sv
hdl/mste_ram.sv
hdl/mste_datapath.sv
hdl/mste_ctrl.sv
hdl/multi_slot_timeout_engine.sv
hdl/mste_checker.sv
verif/mste_tb_pkg.sv
verif/tb_multi_slot_timeout_engine.sv
